// File: hw/rtl/epcal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch calendar package
// Shared constants, types and calendar tables for the epoch seconds to
// calendar converter and its divider.
// ----------------------------------------------------------------------------
package epcal_pkg;

    localparam int SECONDS_WIDTH_DEF = 40;

    // Quotient bits resolved by the divider in each cycle.
    localparam int DIV_DIGITS = 4;
    // Wide enough for the step count of a 56-bit dividend.
    localparam int DIV_STEP_W = 4;
    localparam int DVSR_W     = 17;

    localparam int HOUR_REM_W = 12;
    localparam int YDAY_W     = 9;
    localparam int MDAY_W     = 10;

    localparam logic [DVSR_W-1:0] DVSR_DAY   = 17'd86400;
    localparam logic [DVSR_W-1:0] DVSR_HOUR  = 17'd3600;
    localparam logic [DVSR_W-1:0] DVSR_MIN   = 17'd60;
    localparam logic [DVSR_W-1:0] DVSR_WEEK  = 17'd7;
    localparam logic [DVSR_W-1:0] DVSR_QUAD  = 17'd1461;
    localparam logic [DVSR_W-1:0] DVSR_CENT  = 17'd100;
    localparam logic [DVSR_W-1:0] DVSR_QCENT = 17'd400;
    localparam logic [DVSR_W-1:0] DVSR_MONTH = 17'd30;

    localparam int EPOCH_WDAY    = 4;
    localparam int YEAR_OFFSET   = 70;
    localparam int CENT_OFFSET   = 69;
    localparam int QCENT_OFFSET  = 369;
    localparam int DAYS_PER_YEAR = 365;

    localparam logic [6:0] CENT_REM_LAST  = 7'd99;
    localparam logic [8:0] QCENT_REM_LAST = 9'd399;

    typedef logic [3:0] t_month;

    localparam t_month MONTH_JAN  = 4'd0;
    localparam t_month MONTH_FEB  = 4'd1;
    localparam t_month MONTH_LAST = 4'd11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAYS,
        S_HOUR,
        S_MIN,
        S_WDAY,
        S_YEST,
        S_YLOOP,
        S_Y100,
        S_Y400,
        S_YSUM,
        S_YCMP,
        S_MEST,
        S_MFIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_cmd;

    // Days before the first of the month.
    function automatic logic [8:0] f_cum_days(input logic leap, input t_month m);
        logic [8:0] base;
        unique case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m > MONTH_FEB) && (m <= MONTH_LAST)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    function automatic logic [4:0] f_month_len(input logic leap, input t_month m);
        logic [4:0] len;
        unique case (m)
            4'd1:                         len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
            default:                      len = 5'd31;
        endcase
        if (leap && (m == MONTH_FEB)) begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

// File: hw/rtl/epcal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch calendar divider
// Shared restoring divider, several quotient bits per cycle, for a dividend
// loaded left-aligned so that only its significant digits are worked through.
// ----------------------------------------------------------------------------
module epcal_div #(
    parameter int DIVIDEND_W = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  epcal_pkg::t_div_cmd          i_cmd,
    input  logic [DIVIDEND_W-1:0]        i_dividend,
    input  logic [epcal_pkg::DVSR_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [DIVIDEND_W-1:0]        o_quotient,
    output logic [epcal_pkg::DVSR_W-1:0] o_remainder
);
    import epcal_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVIDEND_W-1:0] n_quo;
    logic [DVSR_W-1:0]     r_rem;
    logic [DVSR_W-1:0]     n_rem;
    logic [DVSR_W-1:0]     r_dvsr;
    logic [DVSR_W:0]       trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < DIV_DIGITS; k++) begin
            trial = {n_rem, n_quo[DIVIDEND_W-1]};
            n_quo = {n_quo[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvsr}) begin
                trial    = trial - {1'b0, r_dvsr};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DVSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_STEP_W'(1);
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: hw/rtl/epoch_seconds_to_calendar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar converter
// Breaks a count of seconds since 1970-01-01 UTC into Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on i_valid / i_seconds and is taken when o_stall is low;
// o_stall stays high from then until the converted date has been placed in
// the output register. The result leaves on o_valid and the o_* fields and is
// taken at an edge where i_stall is low. While i_stall holds a result, its
// fields do not change, and a new request is still taken and worked on; it
// waits at the end only if the earlier result has not yet left.
// All divisions run through one shared divider that resolves four quotient
// bits a cycle; the time a request takes is the sum of its runs and of the
// states between them. At the default width the year estimate is at most
// one low and each correction repeats the century divisions and the year
// sum; the month estimate is at most one off and is put right in S_MFIX.
// The next request can be taken in the cycle after a result is loaded, so
// requests are worked on one at a time. Reset returns the sequencer to
// idle and empties the output register; nothing else needs clearing.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core #(
    parameter int SECONDS_WIDTH = epcal_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SECONDS_WIDTH-1:0] i_seconds,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [5:0]               o_second,
    output logic [5:0]               o_minute,
    output logic [4:0]               o_hour,
    output logic [2:0]               o_weekday,
    output logic [15:0]              o_year_since_1900,
    output logic [8:0]               o_day_of_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day_of_month
);
    import epcal_pkg::*;

    localparam int DW     = ((SECONDS_WIDTH + DIV_DIGITS - 1) / DIV_DIGITS) * DIV_DIGITS;
    localparam int DAYS_W = SECONDS_WIDTH - 16;
    localparam int Y_W    = SECONDS_WIDTH - 24;
    localparam int YL_W   = Y_W + 1;
    localparam int YS_W   = ((Y_W > 9) ? Y_W : 9) + 1;
    localparam int YST_W  = DAYS_W + 1;
    localparam int YD_W   = DAYS_W + 2;
    localparam int YO_W   = (Y_W + 1 > 16) ? Y_W + 1 : 16;

    localparam int ST_DAY  = (SECONDS_WIDTH + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int ST_HOUR = (DVSR_W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int ST_MIN  = (HOUR_REM_W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int ST_WDAY = (DAYS_W + 1 + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int ST_QUAD = (DAYS_W + 2 + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int ST_CENT = (YS_W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int ST_MON  = (YDAY_W + DIV_DIGITS - 1) / DIV_DIGITS;

    localparam int SH_DAY  = DW - ST_DAY * DIV_DIGITS;
    localparam int SH_HOUR = DW - ST_HOUR * DIV_DIGITS;
    localparam int SH_MIN  = DW - ST_MIN * DIV_DIGITS;
    localparam int SH_WDAY = DW - ST_WDAY * DIV_DIGITS;
    localparam int SH_QUAD = DW - ST_QUAD * DIV_DIGITS;
    localparam int SH_CENT = DW - ST_CENT * DIV_DIGITS;
    localparam int SH_MON  = DW - ST_MON * DIV_DIGITS;

    t_state r_state;
    t_state n_state;

    t_div_cmd          div_cmd;
    logic [DW-1:0]     div_dividend;
    logic [DVSR_W-1:0] div_divisor;
    logic              div_done;
    logic [DW-1:0]     div_quo;
    logic [DVSR_W-1:0] div_rem;

    logic [5:0]        r_sec;
    logic [5:0]        r_min;
    logic [4:0]        r_hour;
    logic [2:0]        r_wday;
    logic [DAYS_W-1:0] r_days;
    logic [Y_W-1:0]    r_y;
    logic [Y_W-1:0]    r_q100;
    logic [Y_W-1:0]    r_q400;
    logic [6:0]        r_r100;
    logic [8:0]        r_r400;
    logic [YST_W-1:0]  r_ystart;
    logic              r_leap;
    logic [8:0]        r_yday;
    t_month            r_mon;
    logic [4:0]        r_mday;

    logic              r_out_valid;
    logic [5:0]        r_out_second;
    logic [5:0]        r_out_minute;
    logic [4:0]        r_out_hour;
    logic [2:0]        r_out_weekday;
    logic [15:0]       r_out_year;
    logic [8:0]        r_out_yday;
    logic [3:0]        r_out_month;
    logic [4:0]        r_out_mday;

    logic              in_accept;
    logic              out_load;
    logic [YL_W-1:0]   leaps;
    logic [1:0]        year_low;
    logic              year_leap;
    logic [YD_W-1:0]   yday;
    logic              yday_neg;
    logic              yday_over;
    logic [MDAY_W-1:0] mday;
    logic              mday_low;
    logic              mday_high;
    logic              mon_dec;
    logic              mon_inc;
    logic [3:0]        mon_est;
    logic [YO_W-1:0]   year_out;

    epcal_div #(
        .DIVIDEND_W (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (div_cmd),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // Leap days before the candidate year, and whether the year itself is leap.
    // The remainders of the century divisions tell when the calendar year is
    // a multiple of 100 or 400.
    assign leaps     = ((YL_W'(r_y) + YL_W'(1)) >> 2) - YL_W'(r_q100) + YL_W'(r_q400);
    assign year_low  = r_y[1:0] + 2'd2;
    assign year_leap = (year_low == 2'd0) &&
                       ((r_r100 != CENT_REM_LAST) || (r_r400 == QCENT_REM_LAST));

    assign yday      = YD_W'(r_days) - YD_W'(r_ystart);
    assign yday_neg  = yday[YD_W-1];
    assign yday_over = !yday_neg &&
                       (yday >= (YD_W'(DAYS_PER_YEAR) + YD_W'(r_leap)));

    assign mday      = MDAY_W'(r_yday) + MDAY_W'(1) - MDAY_W'(f_cum_days(r_leap, r_mon));
    assign mday_low  = mday[MDAY_W-1] || (mday == '0);
    assign mday_high = !mday[MDAY_W-1] &&
                       (mday > MDAY_W'(f_month_len(r_leap, r_mon)));
    assign mon_dec   = mday_low && (r_mon != MONTH_JAN);
    assign mon_inc   = !mon_dec && mday_high && (r_mon != MONTH_LAST);

    assign mon_est   = (div_quo[3:0] > MONTH_LAST) ? MONTH_LAST : div_quo[3:0];
    assign year_out  = YO_W'(r_y) + YO_W'(YEAR_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        div_cmd      = '0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_DAY)};
                    div_dividend = DW'(i_seconds) << SH_DAY;
                    div_divisor  = DVSR_DAY;
                    n_state      = S_DAYS;
                end
            end
            S_DAYS: begin
                if (div_done) begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_HOUR)};
                    div_dividend = DW'(div_rem) << SH_HOUR;
                    div_divisor  = DVSR_HOUR;
                    n_state      = S_HOUR;
                end
            end
            S_HOUR: begin
                if (div_done) begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_MIN)};
                    div_dividend = DW'(div_rem[HOUR_REM_W-1:0]) << SH_MIN;
                    div_divisor  = DVSR_MIN;
                    n_state      = S_MIN;
                end
            end
            S_MIN: begin
                if (div_done) begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_WDAY)};
                    div_dividend = (DW'(r_days) + DW'(EPOCH_WDAY)) << SH_WDAY;
                    div_divisor  = DVSR_WEEK;
                    n_state      = S_WDAY;
                end
            end
            S_WDAY: begin
                if (div_done) begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_QUAD)};
                    div_dividend = (DW'(r_days) << 2) << SH_QUAD;
                    div_divisor  = DVSR_QUAD;
                    n_state      = S_YEST;
                end
            end
            S_YEST: begin
                if (div_done) begin
                    n_state = S_YLOOP;
                end
            end
            S_YLOOP: begin
                div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_CENT)};
                div_dividend = (DW'(r_y) + DW'(CENT_OFFSET)) << SH_CENT;
                div_divisor  = DVSR_CENT;
                n_state      = S_Y100;
            end
            S_Y100: begin
                if (div_done) begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_CENT)};
                    div_dividend = (DW'(r_y) + DW'(QCENT_OFFSET)) << SH_CENT;
                    div_divisor  = DVSR_QCENT;
                    n_state      = S_Y400;
                end
            end
            S_Y400: begin
                if (div_done) begin
                    n_state = S_YSUM;
                end
            end
            S_YSUM: begin
                n_state = S_YCMP;
            end
            S_YCMP: begin
                if (yday_neg || yday_over) begin
                    n_state = S_YLOOP;
                end else begin
                    div_cmd      = '{start: 1'b1, steps: DIV_STEP_W'(ST_MON)};
                    div_dividend = DW'(yday[YDAY_W-1:0]) << SH_MON;
                    div_divisor  = DVSR_MONTH;
                    n_state      = S_MEST;
                end
            end
            S_MEST: begin
                if (div_done) begin
                    n_state = S_MFIX;
                end
            end
            S_MFIX: begin
                if (!mon_dec && !mon_inc) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Working registers, captured as each divider run completes and in the year and month correction states.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DAYS: begin
                if (div_done) begin
                    r_days <= div_quo[DAYS_W-1:0];
                end
            end
            S_HOUR: begin
                if (div_done) begin
                    r_hour <= div_quo[4:0];
                end
            end
            S_MIN: begin
                if (div_done) begin
                    r_min <= div_quo[5:0];
                    r_sec <= div_rem[5:0];
                end
            end
            S_WDAY: begin
                if (div_done) begin
                    r_wday <= div_rem[2:0];
                end
            end
            S_YEST: begin
                if (div_done) begin
                    r_y <= div_quo[Y_W-1:0];
                end
            end
            S_Y100: begin
                if (div_done) begin
                    r_q100 <= div_quo[Y_W-1:0];
                    r_r100 <= div_rem[6:0];
                end
            end
            S_Y400: begin
                if (div_done) begin
                    r_q400 <= div_quo[Y_W-1:0];
                    r_r400 <= div_rem[8:0];
                end
            end
            S_YSUM: begin
                r_ystart <= YST_W'(r_y) * YST_W'(DAYS_PER_YEAR) + YST_W'(leaps);
                r_leap   <= year_leap;
            end
            S_YCMP: begin
                if (yday_neg) begin
                    r_y <= r_y - Y_W'(1);
                end else if (yday_over) begin
                    r_y <= r_y + Y_W'(1);
                end else begin
                    r_yday <= yday[YDAY_W-1:0];
                end
            end
            S_MEST: begin
                if (div_done) begin
                    r_mon <= mon_est;
                end
            end
            S_MFIX: begin
                if (mon_dec) begin
                    r_mon <= r_mon - 4'd1;
                end else if (mon_inc) begin
                    r_mon <= r_mon + 4'd1;
                end else begin
                    r_mday <= mday[4:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_second  <= r_sec;
            r_out_minute  <= r_min;
            r_out_hour    <= r_hour;
            r_out_weekday <= r_wday;
            r_out_year    <= year_out[15:0];
            r_out_yday    <= r_yday;
            r_out_month   <= r_mon;
            r_out_mday    <= r_mday;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_second          = r_out_second;
    assign o_minute          = r_out_minute;
    assign o_hour            = r_out_hour;
    assign o_weekday         = r_out_weekday;
    assign o_year_since_1900 = r_out_year;
    assign o_day_of_year     = r_out_yday;
    assign o_month           = r_out_month;
    assign o_day_of_month    = r_out_mday;

endmodule
